@@ hw/rtl/chte_pkg.sv @@
package chte_pkg;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned SlotW = $clog2(Capacity);
  localparam int unsigned LinkW = SlotW + 1;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpLookup = 2'd1;
  localparam logic [1:0] OpRemove = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [2:0] StAdded    = 3'd0;
  localparam logic [2:0] StUpdated  = 3'd1;
  localparam logic [2:0] StFound    = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StRemoved  = 3'd4;
  localparam logic [2:0] StReserved = 3'd5;
  localparam logic [2:0] StFull     = 3'd6;

  localparam logic [LinkW-1:0] Nil = LinkW'(Capacity);

  typedef struct packed {
    logic [1:0]  operation;
    logic signed [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] entry_count;
  } rsp_t;

endpackage

@@ hw/rtl/chained_hash_table_engine_unit.sv @@
// Channel  Direction  Handshake            Payload
// req      in         req_valid_i/stall_o  chte_pkg::req_t
// rsp      out        rsp_valid_o/stall_i  chte_pkg::rsp_t
// cfg      in         APB                  reserved_key at address 0
// One word at a time. A request reads its bucket head, then compares chain slots in
// turn (each slot costs one read of the slot memory and one compare). A missing key
// adds the SFree state, and a slot taken from the free stack adds SFreeW; a reserved
// key or an unused operation skips the search. After reset a clearing pass empties the
// bucket heads; no word is accepted meanwhile. A new request is taken while a
// result still waits on a stalled output; its result then waits for room.
module chained_hash_table_engine_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_stall_o,
  input  chte_pkg::req_t  req_i,
  output logic            rsp_valid_o,
  input  logic            rsp_stall_i,
  output chte_pkg::rsp_t  rsp_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [0:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import chte_pkg::*;

  localparam logic [0:0] RegReservedKey = 1'b0;

  localparam logic [3:0] SClear = 4'd0;
  localparam logic [3:0] SIdle  = 4'd1;
  localparam logic [3:0] SHead  = 4'd2;
  localparam logic [3:0] SHeadW = 4'd3;
  localparam logic [3:0] SRead  = 4'd4;
  localparam logic [3:0] SCmp   = 4'd5;
  localparam logic [3:0] SFree  = 4'd6;
  localparam logic [3:0] SFreeW = 4'd7;
  localparam logic [3:0] SDone  = 4'd8;
  localparam logic [3:0] SOut   = 4'd9;

  logic [3:0] state_q, state_d;
  logic [31:0] rkey_q;
  req_t req_q;
  logic [SlotW-1:0] bucket_q;
  logic [LinkW-1:0] cur_q, prev_q, last_q, nxt_q, steps_q;
  logic [LinkW-1:0] free_top_q;
  logic [10:0] count_q;
  logic [SlotW-1:0] clr_q;
  logic out_v_q;
  rsp_t out_q;
  logic [2:0] st_q;

  // Memories.
  logic [LinkW-1:0] head_mem [Capacity];
  logic [31:0] key_mem [Capacity];
  logic [31:0] val_mem [Capacity];
  logic [LinkW-1:0] link_mem [Capacity];
  logic [SlotW-1:0] free_mem [Capacity];
  logic [LinkW-1:0] head_rd_q, link_rd_q;
  logic [31:0] key_rd_q;
  logic [SlotW-1:0] free_rd_q;
  logic free_init_q; // free stack not yet written at index: use Capacity-1-index

  logic head_we, slot_we, link_we, val_we, free_we;
  logic [SlotW-1:0] head_wa, slot_wa, link_wa, free_wa, rd_a;
  logic [LinkW-1:0] head_wd, link_wd;
  logic [SlotW-1:0] free_wd;
  logic [SlotW-1:0] ftop_m1;
  logic [31:0] kmag;
  logic req_acc, cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == RegReservedKey);
  assign prdata = rkey_q;
  assign kmag = req_i.key[31] ? (~req_i.key + 32'd1) : req_i.key;
  assign ftop_m1 = SlotW'(free_top_q - LinkW'(1));

  assign req_stall_o = (state_q != SIdle);
  assign req_acc = req_valid_i && !req_stall_o;
  assign rsp_valid_o = out_v_q;
  assign rsp_o = out_q;
  assign rd_a = cur_q[SlotW-1:0];

  // Write port decode per state.
  always_comb begin
    head_we = 1'b0; head_wa = bucket_q; head_wd = Nil;
    slot_we = 1'b0; val_we = 1'b0; slot_wa = cur_q[SlotW-1:0];
    link_we = 1'b0; link_wa = last_q[SlotW-1:0]; link_wd = Nil;
    free_we = 1'b0; free_wa = free_top_q[SlotW-1:0];
    free_wd = cur_q[SlotW-1:0];
    if (state_q == SClear) begin
      head_we = 1'b1; head_wa = clr_q;
    end
    if (state_q == SDone) begin
      if (req_q.operation == OpInsert && st_q == StUpdated) begin
        val_we = 1'b1;
      end else if (req_q.operation == OpInsert && st_q == StAdded) begin
        slot_we = 1'b1; val_we = 1'b1; link_we = 1'b1;
        slot_wa = nxt_q[SlotW-1:0]; link_wa = nxt_q[SlotW-1:0]; link_wd = Nil;
      end else if (st_q == StRemoved) begin
        free_we = (free_top_q < LinkW'(Capacity));
      end
    end
    if (state_q == SOut && st_q == StAdded) begin
      if (last_q < Nil) begin
        link_we = 1'b1; link_wa = last_q[SlotW-1:0]; link_wd = nxt_q;
      end else begin
        head_we = 1'b1; head_wd = nxt_q;
      end
    end
    if (state_q == SOut && st_q == StRemoved) begin
      if (prev_q < Nil) begin
        link_we = 1'b1; link_wa = prev_q[SlotW-1:0]; link_wd = nxt_q;
      end else begin
        head_we = 1'b1; head_wd = nxt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_q <= head_mem[bucket_q];
    if (slot_we) key_mem[slot_wa] <= req_q.key;
    if (val_we) val_mem[slot_wa] <= req_q.value;
    if (link_we) link_mem[link_wa] <= link_wd;
    key_rd_q <= key_mem[rd_a];
    link_rd_q <= link_mem[rd_a];
    if (free_we) free_mem[free_wa] <= free_wd;
    free_rd_q <= free_mem[ftop_m1];
  end

  // Stack entries below the high-water mark are never written; reads there use Capacity-1-index.
  logic [LinkW-1:0] hw_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SClear: if (clr_q == SlotW'(Capacity - 1)) state_d = SIdle;
      SIdle: if (req_acc) state_d = SHead;
      SHead: state_d = SHeadW;
      SHeadW: state_d = SRead;
      SRead: state_d = SCmp;
      SCmp: state_d = SRead;
      SFree: state_d = SFreeW;
      SFreeW: state_d = SDone;
      SDone: state_d = SOut;
      SOut: if (!out_v_q || !rsp_stall_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q <= '0;
      rkey_q <= 32'hFFFF_FFFF;
      free_top_q <= LinkW'(Capacity);
      hw_q <= LinkW'(Capacity);
      count_q <= '0;
      out_v_q <= 1'b0;
      free_init_q <= 1'b0;
    end else begin
      if (cfg_we) rkey_q <= pwdata;
      if (out_v_q && !rsp_stall_i && state_q != SOut) out_v_q <= 1'b0;
      unique case (state_q)
        SClear: begin
          clr_q <= clr_q + SlotW'(1);
          state_q <= state_d;
        end
        SIdle: begin
          if (req_acc) begin
            req_q <= req_i;
            bucket_q <= SlotW'(kmag % Capacity);
            prev_q <= Nil; last_q <= Nil; nxt_q <= Nil;
            steps_q <= '0;
            if (req_i.operation == OpUnused) begin
              st_q <= StNotFound; state_q <= SDone;
            end else if (req_i.key == rkey_q) begin
              st_q <= StReserved; state_q <= SDone;
            end else begin
              st_q <= StNotFound; state_q <= SHead;
            end
          end
        end
        SHead: state_q <= SHeadW;
        SHeadW: begin
          cur_q <= head_rd_q;
          state_q <= (head_rd_q < Nil) ? SRead : SFree;
        end
        SRead: state_q <= SCmp;
        SCmp: begin
          if (key_rd_q == req_q.key) begin
            nxt_q <= link_rd_q;
            st_q <= (req_q.operation == OpInsert) ? StUpdated :
                    (req_q.operation == OpLookup) ? StFound : StRemoved;
            state_q <= SDone;
          end else begin
            last_q <= cur_q; prev_q <= cur_q;
            cur_q <= link_rd_q;
            steps_q <= steps_q + LinkW'(1);
            if (link_rd_q < Nil && steps_q + LinkW'(1) < LinkW'(Capacity))
              state_q <= SRead;
            else
              state_q <= SFree;
          end
        end
        SFree: begin
          if (req_q.operation != OpInsert) begin
            state_q <= SDone;
          end else if (free_top_q == '0) begin
            st_q <= StFull; state_q <= SDone;
          end else begin
            free_init_q <= (LinkW'(ftop_m1) < hw_q);
            state_q <= SFreeW;
          end
        end
        SFreeW: begin
          free_top_q <= free_top_q - LinkW'(1);
          if (LinkW'(ftop_m1) < hw_q) hw_q <= LinkW'(ftop_m1);
          nxt_q <= free_init_q ? LinkW'(SlotW'(Capacity - 1) - ftop_m1)
                               : LinkW'(free_rd_q);
          st_q <= StAdded;
          state_q <= SDone;
        end
        SDone: begin
          if (st_q == StAdded) count_q <= count_q + 11'd1;
          if (st_q == StRemoved) begin
            if (free_top_q < LinkW'(Capacity)) free_top_q <= free_top_q + LinkW'(1);
            if (count_q != '0) count_q <= count_q - 11'd1;
          end
          state_q <= SOut;
        end
        SOut: begin
          if (!out_v_q || !rsp_stall_i) begin
            out_v_q <= 1'b1;
            out_q.status <= st_q;
            out_q.entry_count <= count_q;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_top_q <= LinkW'(Capacity)) else $error("free top out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SClear |-> req_stall_o) else $error("word accepted during clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDone && st_q == StAdded) |-> nxt_q < Nil)
    else $error("allocated slot out of range");
endmodule

@@ tb/chained_hash_table_engine_unit_tb.sv @@
module chained_hash_table_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chte_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam logic [0:0] AddrReservedKey = 1'b0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid_i = 1'b0;
  logic        req_stall_o;
  req_t        req_i = '0;
  logic        rsp_valid_o;
  logic        rsp_stall_i = 1'b0;
  rsp_t        rsp_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  chained_hash_table_engine_unit u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the table.
  logic [31:0]      shadow_reserved;
  logic [LinkW-1:0] shadow_head [Capacity];
  logic [31:0]      shadow_key  [Capacity];
  logic [31:0]      shadow_val  [Capacity];
  logic [LinkW-1:0] shadow_link [Capacity];
  logic [SlotW-1:0] shadow_free [Capacity];
  int unsigned      shadow_free_top;
  int unsigned      shadow_held;

  rsp_t        expected_rsp_q[$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;

  task automatic shadow_clear();
    shadow_reserved = 32'hFFFF_FFFF;
    for (int i = 0; i < Capacity; i++) begin
      shadow_head[i] = Nil;
      shadow_key[i]  = '0;
      shadow_val[i]  = '0;
      shadow_link[i] = '0;
      shadow_free[i] = SlotW'(Capacity - 1 - i);
    end
    shadow_free_top = Capacity;
    shadow_held = 0;
  endtask

  task automatic predict_table_op(input req_t w, output rsp_t r);
    logic [31:0]      k;
    logic [31:0]      mag;
    int unsigned      b;
    logic [LinkW-1:0] cur, prv, last, hit, s;
    int unsigned      steps;
    logic [2:0]       st;
    k = w.key;
    if (w.operation == OpUnused) begin
      st = StNotFound;
    end else if (k == shadow_reserved) begin
      st = StReserved;
    end else begin
      mag = k[31] ? (~k + 32'd1) : k;
      b = mag % Capacity;
      cur = shadow_head[b];
      prv = Nil;
      last = Nil;
      hit = Nil;
      steps = 0;
      while (cur < Nil && steps < Capacity && hit == Nil) begin
        if (shadow_key[cur] == k) begin
          hit = cur;
        end else begin
          last = cur;
          prv = cur;
          cur = shadow_link[cur];
          steps++;
        end
      end
      if (w.operation == OpInsert) begin
        if (hit < Nil) begin
          shadow_val[hit] = w.value;
          st = StUpdated;
        end else if (shadow_free_top == 0) begin
          st = StFull;
        end else begin
          shadow_free_top--;
          s = LinkW'(shadow_free[shadow_free_top]);
          shadow_key[s] = k;
          shadow_val[s] = w.value;
          shadow_link[s] = Nil;
          if (last < Nil) shadow_link[last] = s;
          else shadow_head[b] = s;
          shadow_held++;
          st = StAdded;
        end
      end else if (w.operation == OpLookup) begin
        st = (hit < Nil) ? StFound : StNotFound;
      end else begin
        if (hit < Nil) begin
          if (prv < Nil) shadow_link[prv] = shadow_link[hit];
          else shadow_head[b] = shadow_link[hit];
          if (shadow_free_top < Capacity) begin
            shadow_free[shadow_free_top] = hit[SlotW-1:0];
            shadow_free_top++;
          end
          if (shadow_held > 0) shadow_held--;
          st = StRemoved;
        end else begin
          st = StNotFound;
        end
      end
    end
    r.status = st;
    r.entry_count = 11'(shadow_held);
  endtask

  task automatic send_word(input logic [1:0] op, input logic [31:0] k, input logic [31:0] v);
    req_t w;
    rsp_t r;
    w.operation = op;
    w.key = k;
    w.value = v;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    req_valid_i = 1'b1;
    req_i = w;
    do @(posedge clk_i); while (req_stall_o);
    predict_table_op(w, r);
    expected_rsp_q.push_back(r);
    words_sent++;
    @(negedge clk_i);
    req_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_rsp_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reserved_key(input logic [31:0] d);
    wait_drained();
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = AddrReservedKey;
    pwdata = d;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow_reserved = d;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      words_checked++;
      if (expected_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: status %0d count %0d",
                                       rsp_o.status, rsp_o.entry_count);
      end else begin
        e = expected_rsp_q.pop_front();
        if (rsp_o.status !== e.status || rsp_o.entry_count !== e.entry_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected status %0d count %0d, got status %0d count %0d",
                     e.status, e.entry_count, rsp_o.status, rsp_o.entry_count);
        end
      end
    end
  end

  // Output stall bursts.
  always @(negedge clk_i) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 11);
    rsp_stall_i = (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed_extremes();
    send_word(OpLookup, 32'h0000_0000, 32'h0);
    send_word(OpInsert, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(OpInsert, 32'h7FFF_FFFF, 32'h0000_0000);
    send_word(OpInsert, 32'h0000_0000, 32'hA5A5_5A5A);
    send_word(OpInsert, 32'hFFFF_FC00, 32'h1);
    send_word(OpInsert, 32'h0000_0400, 32'h2);
    send_word(OpInsert, 32'h0000_0400, 32'h3);
    send_word(OpLookup, 32'h8000_0000, 32'h0);
    send_word(OpLookup, 32'hFFFF_FC00, 32'h0);
    send_word(OpLookup, 32'h0000_0800, 32'h0);
    send_word(OpUnused, 32'h0000_0000, 32'h0);
    send_word(OpRemove, 32'h0000_0000, 32'h0);
    send_word(OpRemove, 32'h0000_0000, 32'h0);
    send_word(OpLookup, 32'h0000_0400, 32'h0);
    send_word(OpRemove, 32'h8000_0000, 32'h0);
    send_word(OpInsert, 32'hFFFF_FFFF, 32'h5);
    send_word(OpLookup, 32'hFFFF_FFFF, 32'h0);
    send_word(OpRemove, 32'hFFFF_FFFF, 32'h0);
  endtask

  task automatic test_reserved_key();
    logic [31:0] picks [4];
    picks = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0400};
    foreach (picks[i]) begin
      write_reserved_key(picks[i]);
      send_word(OpInsert, picks[i], 32'h77);
      send_word(OpLookup, picks[i], 32'h0);
      send_word(OpRemove, picks[i], 32'h0);
      send_word(OpLookup, 32'h7FFF_FFFF, 32'h0);
    end
    write_reserved_key(32'hFFFF_FFFF);
  endtask

  function automatic logic [31:0] pool_key();
    int unsigned b, m;
    logic [31:0] k;
    b = $urandom_range(0, 3);
    b = (b == 3) ? Capacity - 1 : b * 5;
    m = $urandom_range(0, 7);
    k = 32'(b + m * Capacity);
    return $urandom_range(0, 1) ? (~k + 32'd1) : k;
  endfunction

  task automatic test_random_mix(input int unsigned n);
    int unsigned sel;
    logic [1:0]  op;
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) write_reserved_key(pool_key());
      if (i == 2 * n / 3) write_reserved_key($urandom());
      if (i == n - 150) idle_on = 1'b0;
      sel = $urandom_range(0, 99);
      op = (sel < 45) ? OpInsert : (sel < 70) ? OpLookup : (sel < 95) ? OpRemove : OpUnused;
      sel = $urandom_range(0, 19);
      k = (sel == 0) ? shadow_reserved : (sel < 4) ? $urandom() : pool_key();
      send_word(op, k, $urandom());
    end
  endtask

  initial begin
    shadow_clear();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    do @(posedge clk_i); while (req_stall_o);
    @(negedge clk_i);
    test_directed_extremes();
    test_reserved_key();
    test_random_mix(716);
    write_reserved_key(32'hFFFF_FFFF);
    wait_drained();
    repeat (100) @(negedge clk_i);
    $display("Sent %0d request words and checked %0d result words over %0d cycles.",
             words_sent, words_checked, cycles);
    $display("Covered reserved keys, chain collisions, removals and unused operations.");
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_rsp_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ chained_hash_table_engine_unit.f @@
hw/rtl/chte_pkg.sv
hw/rtl/chained_hash_table_engine_unit.sv
tb/chained_hash_table_engine_unit_tb.sv
